/* rtl/ubxd_pkg.sv */
// ----------------------------------------------------------------------------
// UBX deframer package
// Shared constants and the result record that is passed between the parser
// and the output stage.
// ----------------------------------------------------------------------------
package ubxd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CKERR    = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] byte_offset;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic        is_frame_end;
    logic [1:0]  frame_status;
  } result_t;

endpackage

/* rtl/ubxd_parser.sv */
// ----------------------------------------------------------------------------
// UBX frame parser
// Sync hunt, header capture, Fletcher-8 checksum and result generation for
// one received byte per cycle while accept is high.
// ----------------------------------------------------------------------------
module ubxd_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  input  logic [15:0]          max_payload_length,
  output logic                 res_valid,
  output ubxd_pkg::result_t    res
);
  import ubxd_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  class_reg, class_reg_next;
  logic [7:0]  id_reg, id_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] payload_count, payload_count_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  received_sum_a, received_sum_a_next;

  logic [7:0]  add_a;
  logic [15:0] full_length;
  logic [15:0] count_inc;

  assign add_a       = sum_a + rx_byte;
  assign full_length = {rx_byte, length_reg[7:0]};
  assign count_inc   = payload_count + 16'd1;

  always_comb begin
    phase_next          = phase;
    class_reg_next      = class_reg;
    id_reg_next         = id_reg;
    length_reg_next     = length_reg;
    payload_count_next  = payload_count;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    received_sum_a_next = received_sum_a;
    res_valid           = 1'b0;
    res.payload_byte    = 8'd0;
    res.byte_offset     = 16'd0;
    res.msg_class       = class_reg;
    res.msg_id          = id_reg;
    res.payload_length  = length_reg;
    res.is_frame_end    = 1'b1;
    res.frame_status    = ST_OK;
    if (accept) begin
      unique case (phase)
        PH_SYNC2: begin
          if (rx_byte == SYNC_SECOND) begin
            phase_next = PH_CLASS;
          end else if (rx_byte != SYNC_FIRST) begin
            phase_next = PH_HUNT;
          end
        end
        PH_CLASS: begin
          class_reg_next = rx_byte;
          sum_a_next     = rx_byte;
          sum_b_next     = rx_byte;
          phase_next     = PH_ID;
        end
        PH_ID: begin
          id_reg_next = rx_byte;
          sum_a_next  = add_a;
          sum_b_next  = sum_b + add_a;
          phase_next  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length_reg_next = {8'd0, rx_byte};
          sum_a_next      = add_a;
          sum_b_next      = sum_b + add_a;
          phase_next      = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          length_reg_next    = full_length;
          sum_a_next         = add_a;
          sum_b_next         = sum_b + add_a;
          payload_count_next = 16'd0;
          if (full_length > max_payload_length) begin
            phase_next         = PH_HUNT;
            res_valid          = 1'b1;
            res.payload_length = full_length;
            res.frame_status   = ST_TOO_LONG;
          end else if (full_length == 16'd0) begin
            phase_next = PH_CK_A;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_a_next         = add_a;
          sum_b_next         = sum_b + add_a;
          payload_count_next = count_inc;
          if (count_inc >= length_reg) begin
            phase_next = PH_CK_A;
          end
          res_valid        = 1'b1;
          res.payload_byte = rx_byte;
          res.byte_offset  = payload_count;
          res.is_frame_end = 1'b0;
        end
        PH_CK_A: begin
          received_sum_a_next = rx_byte;
          phase_next          = PH_CK_B;
        end
        PH_CK_B: begin
          phase_next = PH_HUNT;
          res_valid  = 1'b1;
          if ((received_sum_a == sum_a) && (rx_byte == sum_b)) begin
            res.frame_status = ST_OK;
          end else begin
            res.frame_status = ST_CKERR;
          end
        end
        default: begin
          phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      class_reg      <= 8'd0;
      id_reg         <= 8'd0;
      length_reg     <= 16'd0;
      payload_count  <= 16'd0;
      sum_a          <= 8'd0;
      sum_b          <= 8'd0;
      received_sum_a <= 8'd0;
    end else begin
      phase          <= phase_next;
      class_reg      <= class_reg_next;
      id_reg         <= id_reg_next;
      length_reg     <= length_reg_next;
      payload_count  <= payload_count_next;
      sum_a          <= sum_a_next;
      sum_b          <= sum_b_next;
      received_sum_a <= received_sum_a_next;
    end
  end

  a_result_needs_accept: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> accept)
    else $error("result produced without an accepted byte");

  a_too_long_result: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_LEN_HI && full_length > max_payload_length)
      |-> (res_valid && res.frame_status == ST_TOO_LONG && res.is_frame_end))
    else $error("oversize length did not end the frame");

  a_ck_b_returns_to_hunt: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_CK_B) |=> (phase == PH_HUNT))
    else $error("parser did not resume hunting after the checksum");

endmodule

/* rtl/ubxd_skid.sv */
// ----------------------------------------------------------------------------
// UBX deframer output stage
// Two-entry skid register between the parser and the result stream, so the
// input side keeps running while a result waits to be taken.
// ----------------------------------------------------------------------------
module ubxd_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ubxd_pkg::result_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ubxd_pkg::result_t  out_data
);
  import ubxd_pkg::*;

  logic    main_valid;
  result_t main_data;
  logic    skid_valid;
  result_t skid_data;
  logic    push;
  logic    pop;

  assign in_ready  = !skid_valid;
  assign push      = in_valid && in_ready;
  assign pop       = main_valid && out_ready;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          main_data  <= skid_data;
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        if (!main_valid || pop) begin
          main_data  <= in_data;
          main_valid <= 1'b1;
        end else begin
          skid_data  <= in_data;
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        main_valid <= 1'b0;
      end
    end
  end

  a_skid_implies_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held while the output register is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (push && main_valid && !out_ready) |=> skid_valid)
    else $error("request taken during a stall was not kept in the skid entry");

  a_skid_moves_forward: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && pop) |=> (main_valid && !skid_valid && main_data == $past(skid_data)))
    else $error("skid entry lost or reordered");

endmodule

/* rtl/ubx_frame_deframer.sv */
// ----------------------------------------------------------------------------
// UBX frame deframer
// Finds UBX frames in a byte stream, emits payload bytes with their offsets
// and one end result per frame carrying the checksum or length verdict.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle and keeps that rate
// indefinitely while the result side is ready. Each byte is handled by the
// parser in the cycle it is accepted; any result it causes is registered and
// reaches the master side from the output register. While the output
// register is stalled, a second entry holds one more result and bytes that
// cause no result keep flowing; once that entry is also full, s_tready drops
// until the waiting result is taken. max_payload_length is read when the
// high length byte arrives and should only be written while idle.
module ubx_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] payload_byte, [23:8] byte_offset, [31:24] msg_class,
  // [39:32] msg_id, [55:40] payload_length
  output logic [55:0] m_tdata,
  output logic        m_tlast,   // is_frame_end
  output logic [1:0]  m_tuser,   // [1:0] frame_status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ubxd_pkg::*;

  logic [15:0] max_payload_length;
  logic        accept;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, max_payload_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_length <= 16'd92;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      max_payload_length <= pwdata[15:0];
    end
  end

  assign accept = s_tvalid && s_tready;

  ubxd_parser u_parser (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .rx_byte            (s_tdata),
    .max_payload_length (max_payload_length),
    .res_valid          (res_valid),
    .res                (res)
  );

  ubxd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (s_tready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {out_res.payload_length, out_res.msg_id, out_res.msg_class,
                    out_res.byte_offset, out_res.payload_byte};
  assign m_tlast = out_res.is_frame_end;
  assign m_tuser = out_res.frame_status;

endmodule
